FILE: src/elts_pkg.sv
package elts_pkg;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HORIZON_ROW   = 2'd2;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [15:0] HORIZON_ROW_RST   = 16'd0;

  // result flags in the master-side tuser
  localparam int unsigned USER_ACCEPTED = 0;
  localparam int unsigned USER_FAULT    = 1;

endpackage

FILE: src/elts_div_cell.sv
module elts_div_cell #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] dm_i,
  input  logic [SW-1:0] side_i,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] dm_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [NW-1:0] nq_d;

  // one restoring step: bring down the next numerator bit, try the subtract
  always_comb begin
    trial = {rem_i, nq_i[NW-1]};
    ge    = trial >= {1'b0, dm_i};
    diff  = trial - {1'b0, dm_i};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_d  = {nq_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      nq_o   <= nq_d;
      dm_o   <= dm_i;
      side_o <= side_i;
    end
  end

endmodule

FILE: src/extend_line_to_screen_edges_unit.sv
// Channel   | Signals                                   | Item
// ----------+-------------------------------------------+------------------------------------
// s_axis    | s_axis_tvalid/tready/tdata                | segment: start_x,start_y,end_x,end_y
// m_axis    | m_axis_tvalid/tready/tdata/tuser          | extended segment and flags
// cfg       | cfg_valid_i/cfg_ready_o/cfg_addr_i/data_i | register write, always ready
//
// One item per clock is accepted and delivered while the output is not stalled. From input to
// output handshake the path is: input register, operand stage, multiply of an MW-bit by a
// COORD_BITS-bit magnitude (MW = max(COORD_BITS,14)), one restoring divider cell per quotient
// bit in each of four lanes, fix-up and output register.
// Reset clears valid bits and the configuration registers to 640, 480 and 0.
// A stalled output fills a skid register; only then does the input stall.
module extend_line_to_screen_edges_unit #(
  parameter int unsigned COORD_BITS = elts_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_TW  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [IN_TW-1:0]                 s_axis_tdata,  // start_x, start_y, end_x, end_y
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [OUT_TW-1:0]                m_axis_tdata,  // out_start_x, out_start_y, out_end_x, out_end_y
  output logic [1:0]                       m_axis_tuser,  // accepted, divide_fault
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [elts_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [elts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import elts_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned MW = (C > 14) ? C : 14;
  localparam int unsigned EW = MW + 1;
  localparam int unsigned PW = MW + C;
  localparam int unsigned RW = PW + 2;

  // configuration registers
  logic        [12:0] width_q, height_q;
  logic signed [15:0] horizon_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SCREEN_WIDTH_RST;
      height_q  <= SCREEN_HEIGHT_RST;
      horizon_q <= HORIZON_ROW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_SCREEN_WIDTH:  width_q   <= cfg_data_i[12:0];
        REG_SCREEN_HEIGHT: height_q  <= cfg_data_i[12:0];
        REG_HORIZON_ROW:   horizon_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // edges and clamped horizon
  logic signed [17:0] wm1_w, hm1_w, hz_w;
  always_comb begin
    wm1_w = 18'($signed({1'b0, width_q})) - 18'sd1;
    hm1_w = 18'($signed({1'b0, height_q})) - 18'sd1;
    hz_w  = 18'(horizon_q);
    if (hz_w > hm1_w) hz_w = hm1_w;
    if (hz_w < 0)     hz_w = '0;
  end

  logic adv;
  logic skid_v_q, out_v_q;
  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  // stage 0: input register
  logic               v0_q;
  logic signed [C-1:0] x1_q, y1_q, x2_q, y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= $signed(s_axis_tdata[C-1:0]);
      y1_q <= $signed(s_axis_tdata[2*C-1:C]);
      x2_q <= $signed(s_axis_tdata[3*C-1:2*C]);
      y2_q <= $signed(s_axis_tdata[4*C-1:3*C]);
    end
  end

  // stage 1: differences, case split and lane operands
  logic signed [C:0]    dx, dy;
  logic        [C-1:0]  adx, ady;
  logic                 rej, hor, dyz, dyp;
  logic signed [EW-1:0] wm1e, hm1e, hze;
  logic signed [EW-1:0] m1 [4];
  logic        [C-1:0]  m2m [4], dmm [4];
  logic                 ngl [4];
  logic signed [C-1:0]  al [4];

  always_comb begin
    dx   = (C+1)'(x2_q) - (C+1)'(x1_q);
    dy   = (C+1)'(y2_q) - (C+1)'(y1_q);
    adx  = C'(dx < 0 ? -dx : dx);
    ady  = C'(dy < 0 ? -dy : dy);
    rej  = (x1_q == '1 && y1_q == '1) || (x2_q == '1 && y2_q == '1) ||
           (x1_q == x2_q && y1_q == y2_q);
    hor  = adx > ady;
    dyz  = dy == '0;
    dyp  = !dy[C] && !dyz;
    wm1e = EW'(wm1_w);
    hm1e = EW'(hm1_w);
    hze  = EW'(hz_w);
    // left crossing row: y1 + x1*(-dy)/dx
    m1[0] = EW'(x1_q);         m2m[0] = ady; dmm[0] = adx; al[0] = y1_q;
    ngl[0] = m1[0][EW-1] ^ dyp ^ dx[C];
    // right crossing row: y2 + (w-1-x2)*dy/dx
    m1[1] = wm1e - EW'(x2_q);  m2m[1] = ady; dmm[1] = adx; al[1] = y2_q;
    ngl[1] = m1[1][EW-1] ^ dy[C] ^ dx[C];
    // x at horizon from the first point
    m1[2] = hze - EW'(y1_q);   m2m[2] = adx; dmm[2] = ady; al[2] = x1_q;
    ngl[2] = m1[2][EW-1] ^ dx[C] ^ dy[C];
    // x at horizon (horizontal) or bottom row (vertical) from the second point
    m1[3] = (hor ? hze : hm1e) - EW'(y2_q);
    m2m[3] = adx; dmm[3] = ady; al[3] = x2_q;
    ngl[3] = m1[3][EW-1] ^ dx[C] ^ dy[C];
  end

  logic                v1_q, v2_q;
  logic [2:0]          fl1_q, fl2_q;
  logic [MW-1:0]       m1m_q [4];
  logic [C-1:0]        m2m_q [4], dm1_q [4], dm2_q [4];
  logic                ng1_q [4], ng2_q [4];
  logic signed [C-1:0] a1_q [4], a2_q [4];
  logic [PW-1:0]       p_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // stage 1 and 2 payload: magnitudes, then products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl1_q <= {rej, hor, dyz};
      fl2_q <= fl1_q;
      for (int l = 0; l < 4; l++) begin
        m1m_q[l] <= MW'(m1[l] < 0 ? -m1[l] : m1[l]);
        m2m_q[l] <= m2m[l];
        dm1_q[l] <= dmm[l];
        ng1_q[l] <= ngl[l];
        a1_q[l]  <= al[l];
        p_q[l]   <= PW'(m1m_q[l]) * PW'(m2m_q[l]);
        dm2_q[l] <= dm1_q[l];
        ng2_q[l] <= ng1_q[l];
        a2_q[l]  <= a1_q[l];
      end
    end
  end

  // divider chains: one quotient bit per cell
  logic [C-1:0]  rem_w  [4][PW+1];
  logic [PW-1:0] nq_w   [4][PW+1];
  logic [C-1:0]  dm_w   [4][PW+1];
  logic [C:0]    side_w [4][PW+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign rem_w[l][0]  = '0;
    assign nq_w[l][0]   = p_q[l];
    assign dm_w[l][0]   = dm2_q[l];
    assign side_w[l][0] = {ng2_q[l], a2_q[l]};
    for (genvar k = 0; k < PW; k++) begin : g_cell
      elts_div_cell #(.NW(PW), .DW(C), .SW(C + 1)) u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .rem_i  (rem_w[l][k]),
        .nq_i   (nq_w[l][k]),
        .dm_i   (dm_w[l][k]),
        .side_i (side_w[l][k]),
        .rem_o  (rem_w[l][k+1]),
        .nq_o   (nq_w[l][k+1]),
        .dm_o   (dm_w[l][k+1]),
        .side_o (side_w[l][k+1])
      );
    end
  end

  // valid and case flags travel beside the cells
  logic [PW-1:0] cv_q;
  logic [2:0]    cfl_q [PW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q <= '0;
    else if (adv) cv_q <= {cv_q[PW-2:0], v2_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cfl_q[0] <= fl2_q;
      for (int k = 1; k < PW; k++) cfl_q[k] <= cfl_q[k-1];
    end
  end

  // fix-up: a +/- quotient, truncated toward zero
  logic signed [RW-1:0] r_d [4];
  logic signed [RW-1:0] aR, qR;
  logic                 ngf, rnz;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ngf = side_w[l][PW][C];
      rnz = rem_w[l][PW] != '0;
      aR  = RW'($signed(side_w[l][PW][C-1:0]));
      qR  = $signed({2'b00, nq_w[l][PW]});
      r_d[l] = ngf ? aR - qR : aR + qR;
      if (rnz && !ngf && r_d[l] < 0) r_d[l] = r_d[l] + RW'(1);
      if (rnz && ngf && r_d[l] > 0)  r_d[l] = r_d[l] - RW'(1);
    end
  end

  logic                 vf_q;
  logic [2:0]           flf_q;
  logic signed [RW-1:0] r_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (adv) vf_q <= cv_q[PW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flf_q <= cfl_q[PW-1];
      for (int l = 0; l < 4; l++) r_q[l] <= r_d[l];
    end
  end

  function automatic logic [C-1:0] sat_c(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi, lo;
    hi = $signed({{(RW-C+1){1'b0}}, {(C-1){1'b1}}});
    lo = -hi - RW'(1);
    if (v > hi) return hi[C-1:0];
    if (v < lo) return lo[C-1:0];
    return v[C-1:0];
  endfunction

  // endpoint selection and saturation
  logic signed [RW-1:0] hzR, wR, hR, zR;
  logic signed [RW-1:0] ox1, oy1, ox2, oy2;
  logic                 f_rej, f_hor, f_dyz, fault;
  logic [OUT_TW-1:0]    res_data;
  logic [1:0]           res_user;

  always_comb begin
    {f_rej, f_hor, f_dyz} = flf_q;
    hzR   = RW'(hz_w);
    wR    = RW'(wm1_w);
    hR    = RW'(hm1_w);
    zR    = '0;
    fault = 1'b0;
    if (f_hor) begin
      if (r_q[0] >= hzR) begin
        ox1 = zR; oy1 = r_q[0];
      end else begin
        ox1 = f_dyz ? zR : r_q[2]; oy1 = hzR; fault = f_dyz;
      end
      if (r_q[1] >= hzR) begin
        ox2 = wR; oy2 = r_q[1];
      end else begin
        ox2 = f_dyz ? zR : r_q[3]; oy2 = hzR; fault = fault | f_dyz;
      end
    end else begin
      ox1 = f_dyz ? zR : r_q[2]; oy1 = hzR;
      ox2 = f_dyz ? zR : r_q[3]; oy2 = hR;
      fault = f_dyz;
    end
    if (f_rej) begin
      res_data = '0;
      res_user = '0;
    end else begin
      res_data = OUT_TW'({sat_c(oy2), sat_c(ox2), sat_c(oy1), sat_c(ox1)});
      res_user = '0;
      res_user[USER_ACCEPTED] = 1'b1;
      res_user[USER_FAULT]    = fault;
    end
  end

  // output register with skid
  logic [OUT_TW-1:0] out_data_q, skid_data_q;
  logic [1:0]        out_user_q, skid_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) skid_v_q <= 1'b0;
    end else if (vf_q) begin
      if (out_v_q && !m_axis_tready) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (vf_q) begin
      if (out_v_q && !m_axis_tready) begin
        skid_data_q <= res_data;
        skid_user_q <= res_user;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds an item with output empty");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[USER_ACCEPTED] |->
      m_axis_tdata == '0 && !m_axis_tuser[USER_FAULT])
    else $error("rejected item carries data");

  a_fault_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_FAULT] |-> m_axis_tuser[USER_ACCEPTED])
    else $error("fault on rejected item");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_axis_tready |=> skid_v_q && $stable(skid_data_q))
    else $error("skid item lost");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
  import elts_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned LATENCY = 37;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned N_RANDOM = 600;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic   fault;
    logic   accepted;
    coord_t ey;
    coord_t ex;
    coord_t sy;
    coord_t sx;
  } edge_pts_t;

  typedef struct {
    coord_t    sx, sy, ex, ey;
    logic      typed;
    edge_pts_t want;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [4*CB-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [4*CB-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  extend_line_to_screen_edges_unit #(.COORD_BITS(CB)) dut (.*);

  // predictor copy of the configuration
  longint scr_w, scr_h, hz_raw;
  edge_pts_t pending_edges[$];
  int unsigned n_errors, n_results, n_sent, n_faults, n_rejects;
  int unsigned cycle_cnt;
  bit idle_out, long_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // trunc(a + m1*m2/d), exact rational
  function automatic longint affine_trunc(longint a, longint m1, longint m2, longint d);
    longint p, q, r;
    p = m1 * m2;
    if (p == 0) return a;
    q = p / d;
    r = p % d;
    // q is already truncated toward zero; fix the whole when a + q and the fraction differ in sign
    if (r != 0) begin
      if ((p < 0) != (d < 0)) begin
        if (a + q > 0) return a + q - 1;
        return a + q;
      end else begin
        if (a + q < 0) return a + q + 1;
        return a + q;
      end
    end
    return a + q;
  endfunction

  function automatic coord_t sat_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic longint x_at_row(longint px, longint py, longint row, longint dx,
                                      longint dy, ref logic fault);
    if (dy == 0) begin
      fault = 1'b1;
      return 0;
    end
    return affine_trunc(px, row - py, dx, dy);
  endfunction

  function automatic edge_pts_t extend_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    edge_pts_t res;
    longint x1, y1, x2, y2, dx, dy, hz, row, ox1, oy1, ox2, oy2;
    logic fault;
    x1 = sx; y1 = sy; x2 = ex; y2 = ey;
    res = '0;
    fault = 1'b0;
    if ((x1 == -1 && y1 == -1) || (x2 == -1 && y2 == -1) || (x1 == x2 && y1 == y2))
      return res;
    dx = x2 - x1;
    dy = y2 - y1;
    hz = hz_raw;
    if (hz > scr_h - 1) hz = scr_h - 1;
    if (hz < 0) hz = 0;
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
      row = affine_trunc(y1, x1, -dy, dx);
      if (row >= hz) begin
        ox1 = 0; oy1 = row;
      end else begin
        ox1 = x_at_row(x1, y1, hz, dx, dy, fault); oy1 = hz;
      end
      row = affine_trunc(y2, scr_w - 1 - x2, dy, dx);
      if (row >= hz) begin
        ox2 = scr_w - 1; oy2 = row;
      end else begin
        ox2 = x_at_row(x2, y2, hz, dx, dy, fault); oy2 = hz;
      end
    end else begin
      ox1 = x_at_row(x1, y1, hz, dx, dy, fault); oy1 = hz;
      ox2 = x_at_row(x2, y2, scr_h - 1, dx, dy, fault); oy2 = scr_h - 1;
    end
    res.accepted = 1'b1;
    res.fault = fault;
    res.sx = sat_coord(ox1); res.sy = sat_coord(oy1);
    res.ex = sat_coord(ox2); res.ey = sat_coord(oy2);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch on result %0d: %s got %0d want %0d", n_results, what, got, want);
  endtask

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !long_hold && (idle_out ? ($urandom_range(99) >= 36) : 1'b1);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    edge_pts_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      {got.ey, got.ex, got.sy, got.sx} = m_axis_tdata;
      got.accepted = m_axis_tuser[USER_ACCEPTED];
      got.fault = m_axis_tuser[USER_FAULT];
      if (pending_edges.size() == 0) begin
        n_errors++;
        $display("unexpected result at cycle %0d", cycle_cnt);
      end else begin
        want = pending_edges.pop_front();
        if (got.accepted !== want.accepted) report_mismatch("accepted", got.accepted, want.accepted);
        if (got.sx !== want.sx) report_mismatch("out_start_x", got.sx, want.sx);
        if (got.sy !== want.sy) report_mismatch("out_start_y", got.sy, want.sy);
        if (got.ex !== want.ex) report_mismatch("out_end_x", got.ex, want.ex);
        if (got.ey !== want.ey) report_mismatch("out_end_y", got.ey, want.ey);
        if (got.fault !== want.fault) report_mismatch("divide_fault", got.fault, want.fault);
      end
      n_results++;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = val & 16'h1fff;
      REG_SCREEN_HEIGHT: scr_h = val & 16'h1fff;
      REG_HORIZON_ROW:   hz_raw = longint'($signed(val));
      default: ;
    endcase
  endtask

  // offer one segment, idling beforehand at random
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey, bit idle_in,
                              logic typed = 1'b0, edge_pts_t want = '0);
    edge_pts_t pred;
    while (idle_in && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ey, ex, sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = extend_segment(sx, sy, ex, ey);
    if (typed && pred !== want) begin
      n_errors++;
      $display("predictor disagrees with table row %0d", n_sent);
    end
    pending_edges.push_back(typed ? want : pred);
    if (pred.fault) n_faults++;
    if (!pred.accepted) n_rejects++;
    n_sent++;
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(int unsigned mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(1200) - 200);
      2: return coord_t'($urandom_range(8) - 4);
      default: return coord_t'($urandom_range(40) - 20);
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    coord_t sx, sy, ex, ey;
    int unsigned md;
    for (int unsigned i = 0; i < count; i++) begin
      md = $urandom_range(3);
      sx = rand_coord(md); sy = rand_coord(md);
      ex = rand_coord(md); ey = rand_coord(md);
      case ($urandom_range(19))
        0: begin sx = -1; sy = -1; end
        1: begin ex = -1; ey = -1; end
        2: begin ex = sx; ey = sy; end
        3: ey = sy;
        4: ex = sx;
        default: ;
      endcase
      send_segment(sx, sy, ex, ey, idle_out);
    end
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t row_of(coord_t a, coord_t b, coord_t c, coord_t d,
                                       logic typed = 1'b0, edge_pts_t want = '0);
    stim_row_t r;
    r.sx = a; r.sy = b; r.ex = c; r.ey = d; r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    idle_out = 1'b0;
    long_hold = 1'b0;
    scr_w = 640; scr_h = 480; hz_raw = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: rejects, extremes, horizontal and vertical lines
    dir_rows.push_back(row_of(-1, -1, 10, 10, 1'b1, '0));
    dir_rows.push_back(row_of(10, 10, -1, -1, 1'b1, '0));
    dir_rows.push_back(row_of(5, 7, 5, 7, 1'b1, '0));
    dir_rows.push_back(row_of(-1, -1, -1, -1, 1'b1, '0));
    // horizontal line at row 100: crosses both edges at row 100
    dir_rows.push_back(row_of(10, 100, 20, 100, 1'b1, '{1'b0, 1'b1, 100, 639, 100, 0}));
    // vertical line at x 50: horizon to bottom row
    dir_rows.push_back(row_of(50, 10, 50, 20, 1'b1, '{1'b0, 1'b1, 479, 50, 0, 50}));
    dir_rows.push_back(row_of(0, 0, 639, 479));
    dir_rows.push_back(row_of(639, 0, 0, 479));
    dir_rows.push_back(row_of(-32768, -32768, 32767, 32767));
    dir_rows.push_back(row_of(32767, -32768, -32768, 32767));
    dir_rows.push_back(row_of(-32768, 0, 32767, 1));
    dir_rows.push_back(row_of(0, -32768, 1, 32767));
    dir_rows.push_back(row_of(-32768, -32768, -32767, -32768));
    dir_rows.push_back(row_of(1, 2, 3, 2));
    dir_rows.push_back(row_of(0, 0, 1, 1));
    dir_rows.push_back(row_of(0, 5, 1000, -3));
    dir_rows.push_back(row_of(-1, 0, 0, -1));
    dir_rows.push_back(row_of(32767, 32767, 32766, 32767));
    foreach (dir_rows[i])
      send_segment(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey, 1'b0,
                   dir_rows[i].typed, dir_rows[i].want);
    drain_pipe();

    // horizon set low: horizontal lines above it fault
    write_reg(REG_HORIZON_ROW, 16'd200);
    send_segment(10, 100, 20, 100, 1'b0, 1'b1, '{1'b1, 1'b1, 200, 0, 200, 0});
    send_segment(0, 300, 100, 250, 1'b0);
    send_segment(0, 100, 100, 250, 1'b0);
    drain_pipe();

    // default screen, random traffic without idling, with a long receiver hold
    fork
      begin
        repeat (50) @(posedge clk_i);
        long_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      random_phase(150);
    join
    drain_pipe();

    // extremes of the screen registers, idling on both sides
    idle_out = 1'b1;
    write_reg(REG_SCREEN_WIDTH, 16'd1);
    write_reg(REG_SCREEN_HEIGHT, 16'd1);
    write_reg(REG_HORIZON_ROW, 16'h8000);
    random_phase(100);
    drain_pipe();
    write_reg(REG_SCREEN_WIDTH, 16'd4096);
    write_reg(REG_SCREEN_HEIGHT, 16'd4096);
    write_reg(REG_HORIZON_ROW, 16'h7fff);
    random_phase(100);
    drain_pipe();
    write_reg(REG_SCREEN_WIDTH, 16'd0);
    write_reg(REG_SCREEN_HEIGHT, 16'd0);
    write_reg(REG_HORIZON_ROW, 16'd3);
    random_phase(50);
    drain_pipe();
    write_reg(REG_SCREEN_WIDTH, 16'hffff);
    write_reg(REG_SCREEN_HEIGHT, 16'd300);
    write_reg(REG_HORIZON_ROW, 16'd120);
    random_phase(N_RANDOM - 400);
    drain_pipe();

    $display("run covered %0d segments, %0d rejected, %0d with divide fault,",
             n_sent, n_rejects, n_faults);
    $display("over six screen and horizon settings with stalls on both sides");
    if (n_errors == 0 && pending_edges.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
